>>> rtl/ple_pkg.sv
// shared codes and control types for the positional list engine
package ple_pkg;

  // request codes
  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_POS  = 3'd1;
  localparam logic [2:0] CMD_INS_TAIL = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [2:0] CMD_DEL_POS  = 3'd4;
  localparam logic [2:0] CMD_DEL_TAIL = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // fixed field widths
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;

  // decoded request control
  typedef struct packed {
    logic       do_ins;
    logic       do_del;
    logic [1:0] status;
  } ple_ctrl_t;

endpackage

>>> rtl/ple_decode.sv
// request decode: checks the request against the count and picks the target place
module ple_decode import ple_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic [CMD_W-1:0]                    cmd,
  input  logic [POS_W-1:0]                    position,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]     count,
  output ple_ctrl_t                           ctrl,
  output logic [$clog2(LIST_DEPTH)-1:0]       place
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CMP_W-1:0] cnt_e;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] place_w;
  logic             full;
  logic             empty;

  assign cnt_e = CMP_W'(count);
  assign pos_e = CMP_W'(position);
  assign full  = (cnt_e == CMP_W'(LIST_DEPTH));
  assign empty = (cnt_e == '0);
  assign place = place_w[IDX_W-1:0];

  // status and target place per request
  always_comb begin
    ctrl    = '{do_ins: 1'b0, do_del: 1'b0, status: ST_OK};
    place_w = '0;
    unique case (cmd)
      CMD_INS_HEAD: begin
        if (full) ctrl.status = ST_FULL;
        else ctrl.do_ins = 1'b1;
      end
      CMD_INS_POS: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
          ctrl.status = ST_BADPOS;
        end else begin
          ctrl.do_ins = 1'b1;
          place_w     = pos_e - CMP_W'(1);
        end
      end
      CMD_INS_TAIL: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          ctrl.do_ins = 1'b1;
          place_w     = cnt_e;
        end
      end
      CMD_DEL_HEAD: begin
        if (empty) ctrl.status = ST_EMPTY;
        else ctrl.do_del = 1'b1;
      end
      CMD_DEL_POS: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else if (pos_e == '0 || pos_e > cnt_e) begin
          ctrl.status = ST_BADPOS;
        end else begin
          ctrl.do_del = 1'b1;
          place_w     = pos_e - CMP_W'(1);
        end
      end
      CMD_DEL_TAIL: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          ctrl.do_del = 1'b1;
          place_w     = cnt_e - CMP_W'(1);
        end
      end
      default: begin
        ctrl.status = ST_OK;
      end
    endcase
  end

endmodule

>>> rtl/ple_array.sv
// shifting entry array and entry count
module ple_array import ple_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  ple_ctrl_t                           ctrl,
  input  logic [$clog2(LIST_DEPTH)-1:0]       place,
  input  logic signed [VALUE_W-1:0]           value,
  output logic signed [VALUE_W-1:0]           rd_value,
  output logic [$clog2(LIST_DEPTH+1)-1:0]     count,
  output logic [$clog2(LIST_DEPTH+1)-1:0]     count_nxt
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);

  logic signed [VALUE_W-1:0] entries_r   [LIST_DEPTH];
  logic signed [VALUE_W-1:0] entries_nxt [LIST_DEPTH];
  logic [CNT_W-1:0]          count_r;

  assign count    = count_r;
  assign rd_value = entries_r[place];

  // next count
  always_comb begin
    count_nxt = count_r;
    if (en && ctrl.do_ins) count_nxt = count_r + CNT_W'(1);
    else if (en && ctrl.do_del) count_nxt = count_r - CNT_W'(1);
  end

  // per-entry shift select
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_entry
    always_comb begin
      entries_nxt[k] = entries_r[k];
      if (ctrl.do_ins) begin
        if (IDX_W'(k) == place) entries_nxt[k] = value;
        else if (IDX_W'(k) > place) entries_nxt[k] = entries_r[(k > 0) ? k - 1 : 0];
      end else if (ctrl.do_del) begin
        if (IDX_W'(k) >= place && k < LIST_DEPTH - 1)
          entries_nxt[k] = entries_r[(k < LIST_DEPTH - 1) ? k + 1 : k];
      end
    end

    // entry storage, no reset
    always_ff @(posedge clk) begin
      if (en) entries_r[k] <= entries_nxt[k];
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

endmodule

>>> rtl/positional_list_engine_top.sv
// positional list engine: ordered bounded list with head, position and tail requests
// path: a request taken into the input register is decoded and applied to the array,
// and its result is then registered together with the result strobe
// throughput: one request per cycle while busy is low, as all entries shift at once
// reset: synchronous active low, clears the count and pipeline valids; busy is
// high during reset and low otherwise; the receiver cannot stall results
module positional_list_engine_top import ple_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [CMD_W-1:0]                    in_cmd,
  input  logic signed [VALUE_W-1:0]           in_value,
  input  logic [POS_W-1:0]                    in_position,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic signed [VALUE_W-1:0]           out_removed_value,
  output logic [$clog2(LIST_DEPTH+1)-1:0]     out_entry_count
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);

  logic                      busy_r;
  logic                      req_vld_r;
  logic [CMD_W-1:0]          cmd_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]          pos_r;

  ple_ctrl_t                 ctrl;
  logic [IDX_W-1:0]          place;
  logic signed [VALUE_W-1:0] rd_value;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_nxt;

  logic                      strobe_r;
  logic [1:0]                status_r;
  logic signed [VALUE_W-1:0] removed_r;
  logic [CNT_W-1:0]          ecount_r;

  assign busy = busy_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      req_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      req_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  ple_decode #(.LIST_DEPTH(LIST_DEPTH)) u_decode (
    .cmd      (cmd_r),
    .position (pos_r),
    .count    (count),
    .ctrl     (ctrl),
    .place    (place)
  );

  ple_array #(.LIST_DEPTH(LIST_DEPTH)) u_array (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (req_vld_r),
    .ctrl      (ctrl),
    .place     (place),
    .value     (value_r),
    .rd_value  (rd_value),
    .count     (count),
    .count_nxt (count_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= req_vld_r;
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      status_r  <= ctrl.status;
      removed_r <= ctrl.do_del ? rd_value : '0;
      ecount_r  <= count_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = ecount_r;

endmodule

>>> sim/testbench.sv
// self-checking testbench for the positional list engine: directed table then random requests
`timescale 1ns / 100ps

module testbench import ple_pkg::*;;

  localparam int LIST_DEPTH     = 16;
  localparam int CNT_W          = $clog2(LIST_DEPTH + 1);
  localparam int RAND_ITEMS     = 1925;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 10;

  // request codes with no operation behind them
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed;
    logic [CNT_W-1:0]          count;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    int                        reps;
    bit                        typed;
    list_result_t              want;
  } dir_row_t;

  localparam list_result_t NO_WANT = '{ST_OK, 32'sd0, 5'd0};

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      start       = 1'b0;
  logic [CMD_W-1:0]          in_cmd      = '0;
  logic signed [VALUE_W-1:0] in_value    = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      busy;
  logic                      out_strobe;
  logic [1:0]                out_status;
  logic signed [VALUE_W-1:0] out_removed_value;
  logic [CNT_W-1:0]          out_entry_count;

  // predictor state: list contents and length
  logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
  int                        list_len = 0;

  list_result_t pending_results [$];
  int           bad_count   = 0;
  int           result_num  = 0;
  int           idle_cycles = 0;
  bit           gaps_on     = 1'b1;

  // directed table: empty list errors, bad positions, extremes, head/tail by position, spare codes, full list errors
  dir_row_t dir_tab [25] = '{
    '{CMD_DEL_HEAD, 32'sd0,            5'd0,  1,  1'b1, '{ST_EMPTY,  32'sd0, 5'd0}},
    '{CMD_DEL_POS,  32'sd0,            5'd1,  1,  1'b1, '{ST_EMPTY,  32'sd0, 5'd0}},
    '{CMD_DEL_TAIL, 32'sd0,            5'd0,  1,  1'b1, '{ST_EMPTY,  32'sd0, 5'd0}},
    '{CMD_INS_POS,  32'sd5,            5'd0,  1,  1'b1, '{ST_BADPOS, 32'sd0, 5'd0}},
    '{CMD_INS_POS,  32'sd5,            5'd2,  1,  1'b1, '{ST_BADPOS, 32'sd0, 5'd0}},
    '{CMD_INS_HEAD, 32'sh7FFF_FFFF,    5'd0,  1,  1'b1, '{ST_OK,     32'sd0, 5'd1}},
    '{CMD_INS_TAIL, 32'sh8000_0000,    5'd0,  1,  1'b1, '{ST_OK,     32'sd0, 5'd2}},
    '{CMD_INS_POS,  -32'sd1,           5'd1,  1,  1'b1, '{ST_OK,     32'sd0, 5'd3}},
    '{CMD_INS_POS,  32'sd0,            5'd4,  1,  1'b1, '{ST_OK,     32'sd0, 5'd4}},
    '{CMD_INS_POS,  32'sd5,            5'd3,  1,  1'b0, NO_WANT},
    '{CMD_DEL_POS,  32'sd0,            5'd0,  1,  1'b1, '{ST_BADPOS, 32'sd0, 5'd5}},
    '{CMD_DEL_POS,  32'sd0,            5'd6,  1,  1'b1, '{ST_BADPOS, 32'sd0, 5'd5}},
    '{CMD_SPARE_6,  32'sd9,            5'd1,  1,  1'b1, '{ST_OK,     32'sd0, 5'd5}},
    '{CMD_SPARE_7,  32'sd9,            5'd1,  1,  1'b1, '{ST_OK,     32'sd0, 5'd5}},
    '{CMD_DEL_POS,  32'sd0,            5'd2,  1,  1'b0, NO_WANT},
    '{CMD_DEL_HEAD, 32'sd0,            5'd0,  1,  1'b0, NO_WANT},
    '{CMD_DEL_TAIL, 32'sd0,            5'd0,  1,  1'b0, NO_WANT},
    '{CMD_INS_TAIL, 32'sd100,          5'd0,  14, 1'b0, NO_WANT},
    '{CMD_INS_HEAD, 32'sd1,            5'd0,  1,  1'b1, '{ST_FULL,   32'sd0, 5'd16}},
    '{CMD_INS_POS,  32'sd1,            5'd1,  1,  1'b1, '{ST_FULL,   32'sd0, 5'd16}},
    '{CMD_INS_POS,  32'sd1,            5'd31, 1,  1'b1, '{ST_FULL,   32'sd0, 5'd16}},
    '{CMD_INS_TAIL, 32'sd1,            5'd0,  1,  1'b1, '{ST_FULL,   32'sd0, 5'd16}},
    '{CMD_DEL_POS,  32'sd0,            5'd31, 1,  1'b1, '{ST_BADPOS, 32'sd0, 5'd16}},
    '{CMD_DEL_POS,  32'sd0,            5'd16, 1,  1'b0, NO_WANT},
    '{CMD_DEL_POS,  32'sd0,            5'd1,  1,  1'b0, NO_WANT}
  };

  positional_list_engine_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the list copy and return its result
  function automatic list_result_t list_apply(input logic [CMD_W-1:0] c,
                                              input logic signed [VALUE_W-1:0] v,
                                              input logic [POS_W-1:0] p);
    list_result_t r;
    int           slot;
    int           k;
    r.status  = ST_OK;
    r.removed = '0;
    slot      = -1;
    case (c)
      CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
        // full is tested before the position
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else if (c == CMD_INS_HEAD) slot = 0;
        else if (c == CMD_INS_TAIL) slot = list_len;
        else if (int'(p) < 1 || int'(p) > list_len + 1) r.status = ST_BADPOS;
        else slot = int'(p) - 1;
        if (slot >= 0) begin
          for (k = list_len; k > slot; k--) list_mem[k] = list_mem[k-1];
          list_mem[slot] = v;
          list_len++;
        end
      end
      CMD_DEL_HEAD, CMD_DEL_POS, CMD_DEL_TAIL: begin
        // empty is tested before the position
        if (list_len == 0) r.status = ST_EMPTY;
        else if (c == CMD_DEL_HEAD) slot = 0;
        else if (c == CMD_DEL_TAIL) slot = list_len - 1;
        else if (int'(p) < 1 || int'(p) > list_len) r.status = ST_BADPOS;
        else slot = int'(p) - 1;
        if (slot >= 0) begin
          r.removed = list_mem[slot];
          for (k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // drive one request, wait for its transfer, then record the expected result
  task automatic issue_request(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                               input logic [POS_W-1:0] p, input bit typed,
                               input list_result_t typed_want);
    list_result_t model_out;
    while (gaps_on && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_cmd      <= c;
    in_value    <= v;
    in_position <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_out = list_apply(c, v, p);
    pending_results.push_back(typed ? typed_want : model_out);
  endtask

  // hold the sender off until every expected result is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int                        i;
    int                        j;
    int                        insert_pct;
    logic [CMD_W-1:0]          c;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0]          p;
    insert_pct = 50;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      for (j = 0; j < dir_tab[i].reps; j++)
        issue_request(dir_tab[i].cmd, dir_tab[i].value + j, dir_tab[i].pos,
                      dir_tab[i].typed, dir_tab[i].want);
    end
    wait_drained();

    // random requests in phases that lean toward filling or emptying the list, or stay balanced
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      gaps_on = !(i >= 900 && i < 1300);
      if (i == 600 || i == 1500) wait_drained();

      if ($urandom_range(0, 99) < 3) begin
        c = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if ($urandom_range(0, 99) < insert_pct) begin
        case ($urandom_range(0, 2))
          0:       c = CMD_INS_HEAD;
          1:       c = CMD_INS_POS;
          default: c = CMD_INS_TAIL;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       c = CMD_DEL_HEAD;
          1:       c = CMD_DEL_POS;
          default: c = CMD_DEL_TAIL;
        endcase
      end

      // mostly legal positions, sometimes anything the field can carry
      if ($urandom_range(0, 99) < 20) p = POS_W'($urandom_range(0, 31));
      else if (c == CMD_DEL_POS) p = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
      else p = POS_W'($urandom_range(1, list_len + 1));

      case ($urandom_range(0, 19))
        0:       v = 32'sh7FFF_FFFF;
        1:       v = 32'sh8000_0000;
        2:       v = -32'sd1;
        3:       v = 32'sd0;
        default: v = $urandom;
      endcase

      issue_request(c, v, p, 1'b0, NO_WANT);
    end

    // let the last results arrive, then give the verdict
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_strobe) begin
      got = '{out_status, out_removed_value, out_entry_count};
      if (pending_results.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("unexpected result: status %0d removed %0d count %0d",
                   got.status, got.removed, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.removed !== want.removed ||
            got.count !== want.count) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("result %0d: want st %0d rm %0d cnt %0d, got st %0d rm %0d cnt %0d",
                     result_num, want.status, want.removed, want.count,
                     got.status, got.removed, got.count);
        end
      end
      result_num++;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
